// ===== design/cdes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdes_pkg
// Shared types and constants of the drive enable sequencer: phases,
// controlword and statusword codes, result codes and the state record.
// ----------------------------------------------------------------------------
package cdes_pkg;

	localparam int unsigned WordW  = 16;
	localparam int unsigned CountW = 10;
	localparam int unsigned CodeW  = 3;
	localparam int unsigned IndexW = 2;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_ENTRY    = 3'd1,
		PH_FAULT    = 3'd2,
		PH_SHUTDOWN = 3'd3,
		PH_SWITCHON = 3'd4,
		PH_ENABLE   = 3'd5,
		PH_BRAKE    = 3'd6,
		PH_DONE     = 3'd7
	} phase_t;

	localparam logic [WordW-1:0] CW_SHUTDOWN = 16'h0006;
	localparam logic [WordW-1:0] CW_SWITCHON = 16'h0007;
	localparam logic [WordW-1:0] CW_ENABLEOP = 16'h000F;
	localparam logic [WordW-1:0] CW_FAULTRST = 16'h0080;
	localparam logic [WordW-1:0] SW_FAULT    = 16'h0008;

	localparam logic [WordW-1:0] SW_READY_TO_SWITCH_ON = 16'h0021;
	localparam logic [WordW-1:0] SW_SWITCHED_ON        = 16'h0023;
	localparam logic [WordW-1:0] SW_OPERATION_ENABLED  = 16'h0027;

	localparam logic [CodeW-1:0] RC_RUNNING  = 3'd0;
	localparam logic [CodeW-1:0] RC_OK       = 3'd1;
	localparam logic [CodeW-1:0] RC_FAULT    = 3'd2;
	localparam logic [CodeW-1:0] RC_SHUTDOWN = 3'd3;
	localparam logic [CodeW-1:0] RC_SWITCHON = 3'd4;
	localparam logic [CodeW-1:0] RC_ENABLE   = 3'd5;

	localparam logic [IndexW-1:0] REG_STATUS_MASK  = 2'd0;
	localparam logic [IndexW-1:0] REG_FAULT_LIMIT  = 2'd1;
	localparam logic [IndexW-1:0] REG_TRANS_LIMIT  = 2'd2;
	localparam logic [IndexW-1:0] REG_BRAKE_CYCLES = 2'd3;

	localparam logic [WordW-1:0]  STATUS_MASK_RST  = 16'h006F;
	localparam logic [CountW-1:0] FAULT_LIMIT_RST  = 10'd100;
	localparam logic [CountW-1:0] TRANS_LIMIT_RST  = 10'd100;
	localparam logic [CountW-1:0] BRAKE_CYCLES_RST = 10'd20;

	typedef struct packed {
		phase_t             phase;
		logic [CountW-1:0]  cycle_count;
		logic [WordW-1:0]   drive_command;
		logic               brake_state;
		logic [CodeW-1:0]   result;
		logic [CountW-1:0]  retries;
	} seq_state_t;

	typedef struct packed {
		logic [WordW-1:0]  status_mask;
		logic [CountW-1:0] fault_retry_limit;
		logic [CountW-1:0] transition_retry_limit;
		logic [CountW-1:0] release_len;
	} cfg_t;

endpackage

// ===== design/cia402_drive_enable_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia402_drive_enable_sequencer_core
// Brings one CiA 402 drive from switch-on-disabled to operation-enabled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one transfer per fieldbus cycle. tuser = 0 arms the sequence,
//   tuser = 1 carries the statusword received in that cycle in tdata.
//   m_axis: exactly one result per input transfer: the controlword and brake
//   bit for the next cycle, a result code and the poll count of the phase.
//   cfg_*: register writes, only while no transfer is in flight.
// Path: the input register takes the transfer, and the result register loads
//   from it as the item moves on; m_axis_tvalid rises once it is loaded.
//   Throughput: one transfer per cycle while m_axis_tready is high;
//   the sequencer state updates as the input register hands its item on.
// Reset: state returns to idle with controlword 0x0006 and brake engaged,
//   registers return to their default values.
// Stall: when m_axis_tready is low the result register holds, the input
//   register fills, and s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module cia402_drive_enable_sequencer_core
	import cdes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // [15:0] status_word
	input  logic              s_axis_tuser,   // [0] command
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [15:0] control_word, [16] brake_release, [19:17] result_code,
	// [29:20] retries_used, [31:30] zero
	output logic [31:0]       m_axis_tdata,
	input  logic              cfg_we,
	input  logic [IndexW-1:0] cfg_index,
	input  logic [WordW-1:0]  cfg_wdata
);

	cfg_t             cfg;
	seq_state_t       st_q;
	seq_state_t       st_nxt;
	logic             valid_s1;
	logic             command_s1;
	logic [WordW-1:0] status_s1;
	logic             valid_s2;
	seq_state_t       res_s2;
	logic             advance;
	logic             in_xfer;

	cdes_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cdes_step u_step (
		.cur         (st_q),
		.cfg         (cfg),
		.command     (command_s1),
		.status_word (status_s1),
		.nxt         (st_nxt)
	);

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			command_s1 <= s_axis_tuser;
			status_s1  <= s_axis_tdata;
		end
		if (advance) begin
			res_s2 <= st_nxt;
		end
	end

	// sequencer state moves with each item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= PH_IDLE;
			st_q.cycle_count   <= '0;
			st_q.drive_command <= CW_SHUTDOWN;
			st_q.brake_state   <= 1'b0;
			st_q.result        <= RC_RUNNING;
			st_q.retries       <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, res_s2.retries, res_s2.result, res_s2.brake_state,
		res_s2.drive_command};

`ifndef SYNTHESIS
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[19:17] <= RC_ENABLE))
		else $error("result code out of range");

	a_result_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.result != RC_RUNNING) |-> (st_q.phase == PH_DONE))
		else $error("final code reported outside done phase");

	a_full_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && valid_s1) |-> advance)
		else $error("input register overwritten while holding an item");
`endif

endmodule

// ===== design/cdes_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdes_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module cdes_cfg_regs
	import cdes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IndexW-1:0] cfg_index,
	input  logic [WordW-1:0]  cfg_wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.status_mask            <= STATUS_MASK_RST;
			cfg_q.fault_retry_limit      <= FAULT_LIMIT_RST;
			cfg_q.transition_retry_limit <= TRANS_LIMIT_RST;
			cfg_q.release_len            <= BRAKE_CYCLES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STATUS_MASK:  cfg_q.status_mask <= cfg_wdata;
				REG_FAULT_LIMIT:  cfg_q.fault_retry_limit <= cfg_wdata[CountW-1:0];
				REG_TRANS_LIMIT:  cfg_q.transition_retry_limit <= cfg_wdata[CountW-1:0];
				REG_BRAKE_CYCLES: cfg_q.release_len <= cfg_wdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/cdes_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdes_step
// Next-state logic of the power state sequence for one fieldbus transfer.
// ----------------------------------------------------------------------------
module cdes_step
	import cdes_pkg::*;
(
	input  seq_state_t       cur,
	input  cfg_t             cfg,
	input  logic             command,
	input  logic [WordW-1:0] status_word,
	output seq_state_t       nxt
);

	logic [CountW:0]    cnt_inc;
	logic [WordW-1:0]   masked;
	logic [WordW-1:0]   expected;
	logic [CodeW-1:0]   fail_code;
	logic [CountW-1:0]  lim_trans;
	logic [CountW-1:0]  lim_fault;

	assign cnt_inc   = {1'b0, cur.cycle_count} + {{CountW{1'b0}}, 1'b1};
	assign masked    = status_word & cfg.status_mask;
	assign lim_trans = cfg.transition_retry_limit;
	assign lim_fault = cfg.fault_retry_limit;

	always_comb begin
		case (cur.phase)
			PH_SHUTDOWN: begin
				expected  = SW_READY_TO_SWITCH_ON;
				fail_code = RC_SHUTDOWN;
			end
			PH_SWITCHON: begin
				expected  = SW_SWITCHED_ON;
				fail_code = RC_SWITCHON;
			end
			default: begin
				expected  = SW_OPERATION_ENABLED;
				fail_code = RC_ENABLE;
			end
		endcase
	end

	always_comb begin
		nxt = cur;
		if (!command) begin
			nxt.phase       = PH_ENTRY;
			nxt.cycle_count = '0;
			nxt.retries     = '0;
			nxt.result      = RC_RUNNING;
		end else begin
			case (cur.phase)
				PH_ENTRY, PH_FAULT: begin
					if (cur.phase == PH_ENTRY && (status_word & SW_FAULT) != '0) begin
						nxt.drive_command = CW_FAULTRST;
						nxt.cycle_count   = '0;
						nxt.retries       = '0;
						if (lim_fault == '0) begin
							nxt.result = RC_FAULT;
							nxt.phase  = PH_DONE;
						end else begin
							nxt.phase = PH_FAULT;
						end
					end else if ((status_word & SW_FAULT) == '0) begin
						nxt.drive_command = CW_SHUTDOWN;
						nxt.cycle_count   = '0;
						nxt.retries       = '0;
						if (lim_trans == '0) begin
							nxt.result = RC_SHUTDOWN;
							nxt.phase  = PH_DONE;
						end else begin
							nxt.phase = PH_SHUTDOWN;
						end
					end else begin
						// fault bit still set
						nxt.cycle_count = cnt_inc[CountW-1:0];
						nxt.retries     = cnt_inc[CountW-1:0];
						if (cnt_inc >= {1'b0, lim_fault}) begin
							nxt.result = RC_FAULT;
							nxt.phase  = PH_DONE;
						end
					end
				end
				PH_SHUTDOWN, PH_SWITCHON, PH_ENABLE: begin
					if (masked == expected) begin
						nxt.retries     = cur.cycle_count;
						nxt.cycle_count = '0;
						if (cur.phase == PH_ENABLE) begin
							nxt.drive_command = CW_ENABLEOP;
							nxt.brake_state   = 1'b1;
							if (cfg.release_len == '0) begin
								nxt.result = RC_OK;
								nxt.phase  = PH_DONE;
							end else begin
								nxt.phase = PH_BRAKE;
							end
						end else begin
							nxt.retries       = '0;
							nxt.drive_command = (cur.phase == PH_SHUTDOWN) ? CW_SWITCHON
								: CW_ENABLEOP;
							if (lim_trans == '0) begin
								nxt.result = (cur.phase == PH_SHUTDOWN) ? RC_SWITCHON
									: RC_ENABLE;
								nxt.phase  = PH_DONE;
							end else begin
								nxt.phase = (cur.phase == PH_SHUTDOWN) ? PH_SWITCHON
									: PH_ENABLE;
							end
						end
					end else begin
						nxt.cycle_count = cnt_inc[CountW-1:0];
						nxt.retries     = cnt_inc[CountW-1:0];
						if (cnt_inc >= {1'b0, lim_trans}) begin
							nxt.result = fail_code;
							nxt.phase  = PH_DONE;
						end
					end
				end
				PH_BRAKE: begin
					nxt.drive_command = CW_ENABLEOP;
					nxt.brake_state   = 1'b1;
					nxt.cycle_count   = cnt_inc[CountW-1:0];
					if (cnt_inc >= {1'b0, cfg.release_len}) begin
						nxt.result = RC_OK;
						nxt.phase  = PH_DONE;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
